// ===== rtl/core/h264fu_pkg.sv =====
// h264fu_pkg: shared types and constants of the H.264 RTP FU-A packetizer
// used by h264fu_emit and h264_rtp_fu_a_packetizer; no dependencies
`default_nettype none

package h264fu_pkg;

   localparam int MtuBits = 14;

   localparam logic [MtuBits-1:0] MtuReset      = 14'd1400;
   localparam logic [MtuBits-1:0] HeaderBytes   = 14'd12;
   localparam logic [MtuBits-1:0] FuOverhead    = 14'd2;
   localparam logic [MtuBits-1:0] FragMinLimit  = 14'd3;
   localparam logic [MtuBits-1:0] FragSizeFloor = 14'd1;

   localparam logic [7:0] ForbiddenMask = 8'h80;
   localparam logic [7:0] NriMask       = 8'h60;
   localparam logic [4:0] NalTypeMask   = 5'h1F;
   localparam logic [7:0] FuATypeCode   = 8'd28;
   localparam logic [7:0] FuStartBit    = 8'h80;
   localparam logic [7:0] FuEndBit      = 8'h40;

   typedef enum logic [1:0] {
      StepIndicator,
      StepFuHeader,
      StepData
   } step_type;

   // results of one input byte, drained one per cycle while the result port is not stalled
   typedef struct packed {
      logic [7:0]  indicator;
      logic [7:0]  frag_hdr;
      logic [7:0]  data;
      logic [15:0] seq;
      logic [31:0] ts;
      logic        marker;
      logic        data_first;
      logic        data_last;
      logic        has_header;
   } run_type;

endpackage

`default_nettype wire

// ===== rtl/core/h264_rtp_fu_a_packetizer.sv =====
// h264_rtp_fu_a_packetizer: RFC 6184 single NAL unit / FU-A packetizer,
// one NAL unit byte per input transfer. uses h264fu_pkg and h264fu_emit
//
//  channel | ports   | direction | carries
//  --------+---------+-----------+------------------------------------------
//  request | req_*   | in        | NAL byte, unit length, frame end, timestamp
//  result  | rsp_*   | out       | payload byte, seq, timestamp, packet flags
//  config  | csr_*   | in        | mtu_bytes, write only
//
// an input transfer is possible every cycle; a byte that opens a fragment
// yields three results, so the single result port sets the pace: a plain
// byte yields one result, a fragment's first byte three, and the header byte of a
// fragmented unit gives no result. a byte passes the input register, then the
// result register. reset is synchronous and restores mtu_bytes to 1400.
// while a result is stalled the input register holds its byte and req_stall rises
`default_nettype none

module h264_rtp_fu_a_packetizer #(
   parameter int LENGTH_BITS = 20
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire [7:0]             req_data_byte,
   input  wire [LENGTH_BITS-1:0] req_nalu_length,
   input  wire                   req_last_unit_of_frame,
   input  wire [31:0]            req_timestamp,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic [15:0]           rsp_seq_num,
   output logic [31:0]           rsp_pkt_timestamp,
   output logic                  rsp_marker,
   output logic                  rsp_packet_first,
   output logic                  rsp_packet_last,
   output logic                  rsp_run_last,
   input  wire                   csr_wr_en,
   input  wire [13:0]            csr_wr_data
);

   localparam int MB     = h264fu_pkg::MtuBits;
   localparam int LenExtW = LENGTH_BITS + 1;
   localparam int CmpW   = (LENGTH_BITS > MB) ? LENGTH_BITS : MB;

   // configuration
   logic [MB-1:0] mtu_ff;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_data_ff;
   logic [LENGTH_BITS-1:0] in_len_ff;
   logic                   in_frame_ff;
   logic [31:0]            in_ts_ff;

   // packetizer state
   logic [15:0]            seq_ff, seq_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [MB-1:0]          fill_ff, fill_in;
   logic                   mode_ff, mode_in;
   logic [7:0]             ind_ff, ind_in;
   logic [4:0]             type_ff, type_in;
   logic                   first_ff, first_in;
   logic [LENGTH_BITS-1:0] unit_len_ff;
   logic                   unit_frame_ff;
   logic [31:0]            unit_ts_ff;
   logic [MB-1:0]          frag_size_ff;

   // datapath
   logic                   accept, advance, emit_free, emit_load, no_result;
   logic                   pos_zero;
   logic [MB-1:0]          limit, frag_new;
   logic [LENGTH_BITS-1:0] new_len, len_eff, remaining;
   logic                   frame_eff, first_eff, mode_eff;
   logic [31:0]            ts_eff;
   logic [MB-1:0]          frag_eff, fill_eff, room;
   logic                   unit_end, last_frag, pkt_end, frag_full;
   logic [MB:0]            fill_next;
   h264fu_pkg::run_type    run;

   assign accept    = req_valid && !req_stall;
   assign pos_zero  = (pos_ff == '0);

   assign limit    = (mtu_ff > h264fu_pkg::HeaderBytes) ?
                     (mtu_ff - h264fu_pkg::HeaderBytes) : '0;
   assign frag_new = (limit > h264fu_pkg::FragMinLimit) ?
                     (limit - h264fu_pkg::FuOverhead) : h264fu_pkg::FragSizeFloor;
   assign new_len  = (in_len_ff == '0) ? LENGTH_BITS'(1) : in_len_ff;

   assign len_eff   = pos_zero ? new_len : unit_len_ff;
   assign frame_eff = pos_zero ? in_frame_ff : unit_frame_ff;
   assign ts_eff    = pos_zero ? in_ts_ff : unit_ts_ff;
   assign frag_eff  = pos_zero ? frag_new : frag_size_ff;
   assign fill_eff  = pos_zero ? '0 : fill_ff;
   assign first_eff = pos_zero ? 1'b1 : first_ff;
   assign mode_eff  = pos_zero ? (CmpW'(new_len) > CmpW'(limit)) : mode_ff;

   assign unit_end  = (LenExtW'(pos_ff) + LenExtW'(1)) >= LenExtW'(len_eff);
   assign remaining = len_eff - pos_ff;
   assign room      = frag_eff - fill_eff;
   assign last_frag = CmpW'(remaining) <= CmpW'(room);
   assign fill_next = (MB+1)'(fill_eff) + (MB+1)'(1);
   assign frag_full = fill_next >= (MB+1)'(frag_eff);
   assign pkt_end   = unit_end || frag_full;

   assign no_result = mode_eff && pos_zero;
   assign advance   = in_valid_ff && (no_result || emit_free);
   assign emit_load = advance && !no_result;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // one input byte: next state and its run of results
   always_comb begin
      seq_in   = seq_ff;
      fill_in  = fill_eff;
      mode_in  = mode_eff;
      ind_in   = ind_ff;
      type_in  = type_ff;
      first_in = first_eff;
      pos_in   = pos_ff + LENGTH_BITS'(1);

      run.indicator  = ind_ff;
      run.frag_hdr   = {3'b000, type_ff};
      run.data       = in_data_ff;
      run.seq        = seq_ff;
      run.ts         = ts_eff;
      run.marker     = frame_eff;
      run.data_first = pos_zero;
      run.data_last  = unit_end;
      run.has_header = 1'b0;

      priority if (!mode_eff) begin
         if (unit_end) begin
            seq_in = seq_ff + 16'd1;
         end
      end else if (pos_zero) begin
         ind_in  = (in_data_ff & (h264fu_pkg::ForbiddenMask | h264fu_pkg::NriMask))
                   | h264fu_pkg::FuATypeCode;
         type_in = in_data_ff[4:0] & h264fu_pkg::NalTypeMask;
      end else begin
         run.marker     = last_frag && frame_eff;
         run.data_first = 1'b0;
         run.data_last  = pkt_end;
         run.has_header = (fill_eff == '0);
         run.frag_hdr   = {3'b000, type_ff}
                          | (first_eff ? h264fu_pkg::FuStartBit : 8'h00)
                          | ((CmpW'(remaining) <= CmpW'(frag_eff)) ?
                             h264fu_pkg::FuEndBit : 8'h00);
         if (fill_eff == '0) begin
            first_in = 1'b0;
         end
         if (pkt_end) begin
            seq_in  = seq_ff + 16'd1;
            fill_in = '0;
         end else begin
            fill_in = fill_next[MB-1:0];
         end
      end

      if (unit_end) begin
         pos_in   = '0;
         mode_in  = 1'b0;
         fill_in  = '0;
         first_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff        <= h264fu_pkg::MtuReset;
         in_valid_ff   <= 1'b0;
         seq_ff        <= '0;
         pos_ff        <= '0;
         fill_ff       <= '0;
         mode_ff       <= 1'b0;
         ind_ff        <= '0;
         type_ff       <= '0;
         first_ff      <= 1'b1;
         unit_len_ff   <= '0;
         unit_frame_ff <= 1'b0;
         unit_ts_ff    <= '0;
         frag_size_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            mtu_ff <= csr_wr_data;
         end
         if (advance) begin
            seq_ff   <= seq_in;
            pos_ff   <= pos_in;
            fill_ff  <= fill_in;
            mode_ff  <= mode_in;
            ind_ff   <= ind_in;
            type_ff  <= type_in;
            first_ff <= first_in;
            if (pos_zero) begin
               unit_len_ff   <= new_len;
               unit_frame_ff <= in_frame_ff;
               unit_ts_ff    <= in_ts_ff;
               frag_size_ff  <= frag_new;
            end
         end
      end
      if (accept) begin
         in_data_ff  <= req_data_byte;
         in_len_ff   <= req_nalu_length;
         in_frame_ff <= req_last_unit_of_frame;
         in_ts_ff    <= req_timestamp;
      end
   end

   h264fu_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (emit_load),
      .load_run          (run),
      .free              (emit_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_seq_num       (rsp_seq_num),
      .rsp_pkt_timestamp (rsp_pkt_timestamp),
      .rsp_marker        (rsp_marker),
      .rsp_packet_first  (rsp_packet_first),
      .rsp_packet_last   (rsp_packet_last),
      .rsp_run_last      (rsp_run_last)
   );

   // a run is never cut short
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |=> rsp_valid)
      else $error("result run ended before its last transfer");

   // fragment fill stays below the fragment size
   assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> (fill_ff < frag_size_ff))
      else $error("fragment fill reached fragment size");

   // byte position stays inside the unit
   assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (pos_ff < unit_len_ff))
      else $error("byte position beyond unit length");

endmodule

`default_nettype wire

// ===== rtl/core/h264fu_emit.sv =====
// h264fu_emit: result register of the packetizer; holds one run of up to
// three result bytes and sends them one per transfer. uses h264fu_pkg
`default_nettype none

module h264fu_emit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,
   input  wire h264fu_pkg::run_type load_run,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic [15:0]              rsp_seq_num,
   output logic [31:0]              rsp_pkt_timestamp,
   output logic                     rsp_marker,
   output logic                     rsp_packet_first,
   output logic                     rsp_packet_last,
   output logic                     rsp_run_last
);

   logic                 valid_ff, valid_in;
   h264fu_pkg::step_type step_ff, step_in;
   h264fu_pkg::run_type  run_ff, run_in;
   logic                 xfer;
   logic                 last_step;

   assign last_step = (step_ff == h264fu_pkg::StepData);
   assign xfer      = valid_ff && !rsp_stall;
   assign free      = !valid_ff || (xfer && last_step);

   // next state
   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      if (load) begin
         valid_in = 1'b1;
         run_in   = load_run;
         step_in  = load_run.has_header ? h264fu_pkg::StepIndicator
                                        : h264fu_pkg::StepData;
      end else if (xfer) begin
         unique case (step_ff)
            h264fu_pkg::StepIndicator: step_in = h264fu_pkg::StepFuHeader;
            h264fu_pkg::StepFuHeader:  step_in = h264fu_pkg::StepData;
            h264fu_pkg::StepData:      valid_in = 1'b0;
            default:                   valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= h264fu_pkg::StepData;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      run_ff <= run_in;
   end

   // outputs
   always_comb begin
      rsp_valid         = valid_ff;
      rsp_seq_num       = run_ff.seq;
      rsp_pkt_timestamp = run_ff.ts;
      rsp_marker        = run_ff.marker;
      unique case (step_ff)
         h264fu_pkg::StepIndicator: begin
            rsp_out_byte     = run_ff.indicator;
            rsp_packet_first = 1'b1;
            rsp_packet_last  = 1'b0;
            rsp_run_last     = 1'b0;
         end
         h264fu_pkg::StepFuHeader: begin
            rsp_out_byte     = run_ff.frag_hdr;
            rsp_packet_first = 1'b0;
            rsp_packet_last  = 1'b0;
            rsp_run_last     = 1'b0;
         end
         default: begin
            rsp_out_byte     = run_ff.data;
            rsp_packet_first = run_ff.data_first;
            rsp_packet_last  = run_ff.data_last;
            rsp_run_last     = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sim/h264_rtp_fu_a_packetizer_tb.sv =====
`timescale 1ns / 1ps
// h264_rtp_fu_a_packetizer_tb: self-checking bench for the RTP FU-A packetizer, a directed
// table then random NAL units over several mtu settings, checked against a byte-level model
// needs h264fu_pkg and h264_rtp_fu_a_packetizer
module h264_rtp_fu_a_packetizer_tb;

   localparam int WatchdogLimit = 3000;
   localparam int LongHold = 300;
   localparam int RandomItems = 450;
   localparam int MaxPrinted = 40;

   typedef struct packed {
      logic [7:0]  data;
      logic [19:0] len;
      logic        frame_end;
      logic [31:0] ts;
   } nal_byte_type;

   typedef struct packed {
      logic [7:0]  payload;
      logic [15:0] seq;
      logic [31:0] ts;
      logic        marker;
      logic        pkt_first;
      logic        pkt_last;
      logic        run_last;
   } rtp_byte_type;

   typedef struct packed {
      logic         set_mtu;
      logic [13:0]  mtu;
      nal_byte_type in_byte;
      logic         typed;
      rtp_byte_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic [19:0] req_nalu_length = '0;
   logic        req_last_unit_of_frame = 1'b0;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_seq_num;
   logic [31:0] rsp_pkt_timestamp;
   logic        rsp_marker;
   logic        rsp_packet_first;
   logic        rsp_packet_last;
   logic        rsp_run_last;
   logic        csr_wr_en = 1'b0;
   logic [13:0] csr_wr_data = '0;

   // packetizer model state
   logic [13:0] mtu_now;
   logic [15:0] seq_now;
   int unsigned unit_pos;
   int unsigned frag_fill;
   int unsigned unit_len;
   int unsigned frag_size;
   logic        frag_mode;
   logic        first_frag;
   logic        unit_frame_end;
   logic [7:0]  ind_byte;
   logic [4:0]  hdr_type;
   logic [31:0] unit_ts;

   rtp_byte_type expected_bytes[$];
   dir_row_type  dir_rows[$];
   int           error_count = 0;
   int           checked_count = 0;
   int           idle_cycles = 0;
   logic         sender_calm = 1'b0;

   h264_rtp_fu_a_packetizer i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_nalu_length        (req_nalu_length),
      .req_last_unit_of_frame (req_last_unit_of_frame),
      .req_timestamp          (req_timestamp),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_seq_num            (rsp_seq_num),
      .rsp_pkt_timestamp      (rsp_pkt_timestamp),
      .rsp_marker             (rsp_marker),
      .rsp_packet_first       (rsp_packet_first),
      .rsp_packet_last        (rsp_packet_last),
      .rsp_run_last           (rsp_run_last),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_row(dir_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void queue_payload(logic [7:0] b, logic mk, logic pf, logic pl, logic rl);
      expected_bytes.insert(expected_bytes.size(), '{b, seq_now, unit_ts, mk, pf, pl, rl});
   endfunction

   function automatic void packetize(nal_byte_type it);
      int unsigned len;
      int unsigned limit;
      int unsigned remaining;
      logic        unit_end;
      logic        last_frag;
      logic        pkt_end;
      logic        mk;
      logic [7:0]  fu;
      if (unit_pos == 0) begin
         len = it.len;
         limit = (mtu_now > h264fu_pkg::HeaderBytes) ? mtu_now - h264fu_pkg::HeaderBytes : 0;
         if (len == 0) begin
            len = 1;
         end
         unit_len = len;
         unit_frame_end = it.frame_end;
         unit_ts = it.ts;
         frag_size = (limit > h264fu_pkg::FragMinLimit) ? limit - h264fu_pkg::FuOverhead
                                                        : h264fu_pkg::FragSizeFloor;
         frag_fill = 0;
         first_frag = 1'b1;
         frag_mode = (len > limit);
      end
      unit_end = (unit_pos + 1 >= unit_len);
      if (!frag_mode) begin
         queue_payload(it.data, unit_frame_end, unit_pos == 0, unit_end, 1'b1);
         if (unit_end) begin
            seq_now++;
         end
      end else if (unit_pos == 0) begin
         ind_byte = (it.data & h264fu_pkg::ForbiddenMask) | (it.data & h264fu_pkg::NriMask)
                    | h264fu_pkg::FuATypeCode;
         hdr_type = it.data[4:0] & h264fu_pkg::NalTypeMask;
      end else begin
         remaining = unit_len - unit_pos;
         last_frag = (remaining <= frag_size - frag_fill);
         mk = last_frag & unit_frame_end;
         pkt_end = unit_end || (frag_fill + 1 >= frag_size);
         if (frag_fill == 0) begin
            fu = {3'b000, hdr_type};
            if (first_frag) begin
               fu |= h264fu_pkg::FuStartBit;
            end
            if (remaining <= frag_size) begin
               fu |= h264fu_pkg::FuEndBit;
            end
            queue_payload(ind_byte, mk, 1'b1, 1'b0, 1'b0);
            queue_payload(fu, mk, 1'b0, 1'b0, 1'b0);
            first_frag = 1'b0;
         end
         queue_payload(it.data, mk, 1'b0, pkt_end, 1'b1);
         if (pkt_end) begin
            seq_now++;
            frag_fill = 0;
         end else begin
            frag_fill++;
         end
      end
      if (unit_end) begin
         unit_pos = 0;
         frag_mode = 1'b0;
         frag_fill = 0;
         first_frag = 1'b1;
      end else begin
         unit_pos++;
      end
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_v);
      error_count++;
      if (error_count <= MaxPrinted) begin
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_v);
      end
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic offer(nal_byte_type it);
      int unsigned gap;
      int          r;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 75) begin
         gap = 0;
      end else if (r < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(15, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= it.data;
      req_nalu_length <= it.len;
      req_last_unit_of_frame <= it.frame_end;
      req_timestamp <= it.ts;
      do @(posedge clock); while (req_stall);
      packetize(it);
      @(negedge clock);
   endtask

   task automatic write_mtu(logic [13:0] value);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mtu_now = value;
   endtask

   initial begin : result_side
      int   hold_left;
      int   tick;
      logic receiver_calm;
      logic long_hold_done;
      hold_left = 0;
      tick = 0;
      receiver_calm = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 64 == 0) begin
            receiver_calm = ($urandom_range(0, 3) == 0);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && checked_count >= 150 && req_valid) begin
            // long back-pressure so the block fills and stalls its input
            long_hold_done = 1'b1;
            hold_left = LongHold;
            rsp_stall <= 1'b1;
         end else if (receiver_calm) begin
            rsp_stall <= 1'b0;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:69]:  rsp_stall <= 1'b0;
               [70:96]: begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(0, 2);
               end
               default: begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(10, 40);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      rtp_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (expected_bytes.size() == 0) begin
            report_mismatch("result transfer with none expected", rsp_out_byte, 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.payload)
               report_mismatch("out_byte", rsp_out_byte, want.payload);
            if (rsp_seq_num !== want.seq)
               report_mismatch("seq_num", rsp_seq_num, want.seq);
            if (rsp_pkt_timestamp !== want.ts)
               report_mismatch("pkt_timestamp", rsp_pkt_timestamp, want.ts);
            if (rsp_marker !== want.marker)
               report_mismatch("marker", rsp_marker, want.marker);
            if (rsp_packet_first !== want.pkt_first)
               report_mismatch("packet_first", rsp_packet_first, want.pkt_first);
            if (rsp_packet_last !== want.pkt_last)
               report_mismatch("packet_last", rsp_packet_last, want.pkt_last);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("h264_rtp_fu_a_packetizer_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      nal_byte_type it;
      int           phase;
      int           sent;
      int           phase_sent;
      int unsigned  limit;
      int unsigned  len;
      int unsigned  count;
      int           r;
      logic         lof;
      logic [31:0]  ts;

      mtu_now = h264fu_pkg::MtuReset;
      seq_now = '0;
      unit_pos = 0;
      frag_fill = 0;
      unit_len = 0;
      frag_size = 0;
      frag_mode = 1'b0;
      first_frag = 1'b1;
      unit_frame_end = 1'b0;
      ind_byte = '0;
      hdr_type = '0;
      unit_ts = '0;

      // after reset: one-byte unit with data, frame end and timestamp at their top
      add_row('{1'b0, 14'd0, '{8'hFF, 20'd1, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                '{8'hFF, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1}});
      // zero length acts as one
      add_row('{1'b0, 14'd0, '{8'h00, 20'd0, 1'b0, 32'h0}, 1'b1,
                '{8'h00, 16'd1, 32'h0, 1'b0, 1'b1, 1'b1, 1'b1}});
      add_row('{1'b0, 14'd0, '{8'h65, 20'd2, 1'b1, 32'h1234_5678}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h12, 20'hABCDE, 1'b0, 32'h0}, 1'b0, '0});
      // two fragments, forbidden bit set in the header
      add_row('{1'b1, 14'd17, '{8'hE5, 20'd6, 1'b1, 32'hA5A5_A5A5}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h01, 20'hFFFFF, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h02, 20'h00000, 1'b1, 32'h0}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h03, 20'h55555, 1'b0, 32'h5555_5555}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h04, 20'hAAAAA, 1'b1, 32'hAAAA_AAAA}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h05, 20'd1, 1'b0, 32'h1}, 1'b0, '0});
      // length equal to the single-packet limit
      add_row('{1'b0, 14'd0, '{8'h41, 20'd5, 1'b0, 32'h0BAD_F00D}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h00, 20'd9, 1'b1, 32'h0}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'hFF, 20'd0, 1'b0, 32'h0}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h80, 20'd3, 1'b1, 32'h0}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h7F, 20'd1, 1'b0, 32'h0}, 1'b0, '0});
      // tiny mtu: fragment size floors at one byte
      add_row('{1'b1, 14'd14, '{8'h7C, 20'd3, 1'b1, 32'hC0FF_EE00}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h80, 20'd0, 1'b0, 32'h0}, 1'b0, '0});
      add_row('{1'b0, 14'd0, '{8'h7F, 20'd0, 1'b1, 32'h0}, 1'b0, '0});
      // limit at zero: fragmented one-byte unit gives nothing
      add_row('{1'b1, 14'd12, '{8'h68, 20'd1, 1'b1, 32'hDEAD_0001}, 1'b0, '0});
      add_row('{1'b1, 14'd9216, '{8'hFF, 20'd1, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0});

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_mtu) begin
            write_mtu(dir_rows[i].mtu);
         end
         offer(dir_rows[i].in_byte);
         if (dir_rows[i].typed) begin
            expected_bytes[expected_bytes.size() - 1] = dir_rows[i].want;
         end
      end

      phase = 0;
      sent = 0;
      while (sent < RandomItems) begin
         case (phase % 8)
            0: write_mtu(14'd64);
            1: write_mtu(14'd9216);
            2: write_mtu(14'd16);
            3: write_mtu(14'($urandom_range(64, 400)));
            4: write_mtu(14'd14);
            5: write_mtu(14'd12);
            6: write_mtu(14'($urandom_range(6144, 8191)));
            default: write_mtu(14'($urandom_range(64, 160)));
         endcase
         phase++;
         sender_calm = ($urandom_range(0, 3) == 0);
         limit = (mtu_now > h264fu_pkg::HeaderBytes) ? mtu_now - h264fu_pkg::HeaderBytes : 0;
         phase_sent = 0;
         while (phase_sent < 60 && sent < RandomItems) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               len = $urandom_range(0, 2);
            end else if (r < 30 && limit < 140) begin
               len = (limit == 0) ? $urandom_range(0, 2) : limit - 1 + $urandom_range(0, 2);
            end else begin
               len = $urandom_range(1, (2 * limit + 8 < 140) ? 2 * limit + 8 : 140);
            end
            count = (len == 0) ? 1 : len;
            lof = 1'($urandom_range(0, 1));
            ts = $urandom;
            for (int k = 0; k < count; k++) begin
               it.data = 8'($urandom_range(0, 255));
               it.len = (k == 0) ? 20'(len) : 20'($urandom);
               it.frame_end = (k == 0) ? lof : 1'($urandom_range(0, 1));
               it.ts = (k == 0) ? ts : $urandom;
               offer(it);
               sent++;
               phase_sent++;
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("h264_rtp_fu_a_packetizer_tb: done, clean");
      end else begin
         $display("h264_rtp_fu_a_packetizer_tb: done, errors");
      end
      $finish;
   end

endmodule
